// ----- rtl/dpa_pkg.sv -----
`default_nettype none

package dpa_pkg;

  // Field widths fixed by the item formats
  localparam int WORD_W     = 64;
  localparam int INDEX_W    = 11;
  localparam int LEN_W      = 4;
  localparam int COUNT_W    = 12;
  localparam int STATUS_W   = 2;

  // Default sizing
  localparam int DICT_WORDS = 2048;
  localparam int DICT_CHARS = 8;

  // Reset value of the words_in_use register
  localparam logic [COUNT_W-1:0] USE_RESET = COUNT_W'(2048);

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_EXACT    = 2'd0,
    ST_UNIQUE   = 2'd1,
    ST_NONE     = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    mode_t               mode;
    logic [INDEX_W-1:0]  entry_index;
    logic [WORD_W-1:0]   entry_word;
    logic [WORD_W-1:0]   query_word;
    logic [LEN_W-1:0]    query_length;
  } request_t;

  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   completed_word;
    logic [COUNT_W-1:0]  prefix_match_count;
  } result_t;

  // All-ones over the low len bytes; len of 8 or more covers the word
  function automatic logic [WORD_W-1:0] low_bytes_mask(input logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (i < int'(len)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // Keep the first chars bytes, and clear everything from the first zero byte on
  function automatic logic [WORD_W-1:0] normalize_word(input logic [WORD_W-1:0] w,
                                                       input int chars);
    logic [WORD_W-1:0] r;
    logic              alive;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i >= chars || w[8*i +: 8] == 8'h00) alive = 1'b0;
      if (alive) r[8*i +: 8] = w[8*i +: 8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dpa_ram.sv -----
`default_nettype none

module dpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dictionary_prefix_autocomplete.sv -----
`default_nettype none

// Dictionary prefix autocomplete. The dictionary lives in one single-port-read
// memory of TABLE_WORDS 64-bit words, each a zero-terminated word of up to
// WORD_CHARS bytes with byte 0 in bits 7:0. A load item (mode 0) writes one
// entry and gives no result; a load to a slot at or beyond TABLE_WORDS is
// dropped. A query item (mode 1) reads entries 0 up to min(words_in_use,
// TABLE_WORDS)-1, one per cycle through the memory's read port, before its
// result is registered; a query longer than WORD_CHARS, or one that searches
// no entries, skips the scan. The block takes one item at a time, but a
// finished result waits in the output register while the next item is taken.
// Entries must be loaded before any query searches them. The user must write
// words_in_use through the cfg port only while the block is idle; the block
// itself does not enforce it.

module dictionary_prefix_autocomplete
  import dpa_pkg::*;
#(
  parameter int TABLE_WORDS = DICT_WORDS,
  parameter int WORD_CHARS  = DICT_CHARS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               request_valid,
  output logic                    request_stall,
  input  wire request_t           request,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output result_t                 result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_WORDS);

  // Control
  state_t             state;
  state_t             state_next;
  logic [COUNT_W-1:0] words_in_use;
  logic [COUNT_W-1:0] scan_idx;
  logic [COUNT_W-1:0] scan_n;
  logic               rd_valid;

  // Query context and accumulators
  logic [WORD_W-1:0]  q_word;
  logic [LEN_W-1:0]   q_len;
  logic               q_long;
  logic [WORD_W-1:0]  pmask;
  logic [COUNT_W-1:0] hit_count;
  logic               exact_found;
  logic [WORD_W-1:0]  exact_word;
  logic [WORD_W-1:0]  first_word;

  // Datapath nets
  logic               req_fire;
  logic               query_fire;
  logic               load_fire;
  logic               too_long;
  logic [COUNT_W-1:0] n_lim;
  logic               scan_last;
  logic               finish_fire;
  logic               rd_en;
  logic [31:0]        wr_idx_ext;
  logic [31:0]        rd_idx_ext;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [WORD_W-1:0]  rd_data;
  logic               hit;
  logic               ends;
  result_t            result_next;

  assign cfg_ready  = 1'b1;
  assign req_fire   = request_valid && !request_stall;
  assign query_fire = req_fire && request.mode == MODE_QUERY;
  assign load_fire  = req_fire && request.mode == MODE_LOAD &&
                      32'(request.entry_index) < 32'(TABLE_WORDS);
  assign too_long   = 32'(request.query_length) > 32'(WORD_CHARS);

  // Number of entries to search
  assign n_lim = (32'(words_in_use) < 32'(TABLE_WORDS)) ? words_in_use
                                                        : COUNT_W'(TABLE_WORDS);

  assign scan_last = scan_idx == scan_n - COUNT_W'(1);

  // Memory addresses
  assign wr_idx_ext = 32'(request.entry_index);
  assign rd_idx_ext = 32'(scan_idx);
  assign wr_addr    = wr_idx_ext[AW-1:0];
  assign rd_addr    = rd_idx_ext[AW-1:0];

  dpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_WORDS)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_fire),
    .wr_addr (wr_addr),
    .wr_data (normalize_word(request.entry_word, WORD_CHARS)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (query_fire) begin
          state_next = (too_long || n_lim == '0) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!result_valid || !result_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    request_stall = 1'b1;
    rd_en         = 1'b0;
    finish_fire   = 1'b0;
    case (state)
      S_IDLE: begin
        request_stall = 1'b0;
      end
      S_SCAN: begin
        rd_en = 1'b1;
      end
      S_DRAIN: begin
        rd_en = 1'b0;
      end
      S_FINISH: begin
        finish_fire = !result_valid || !result_stall;
      end
      default: begin
        request_stall = 1'b1;
      end
    endcase
  end

  // Compare one returned entry against the query
  assign hit  = ((rd_data ^ q_word) & pmask) == '0;
  assign ends = (32'(q_len) >= 32'(WORD_CHARS)) ||
                (rd_data[{q_len[2:0], 3'b000} +: 8] == 8'h00);

  // Pick the outcome
  always_comb begin
    if (q_long) begin
      result_next.status             = ST_TOO_LONG;
      result_next.completed_word     = q_word;
      result_next.prefix_match_count = '0;
    end else if (exact_found) begin
      result_next.status             = ST_EXACT;
      result_next.completed_word     = exact_word;
      result_next.prefix_match_count = hit_count;
    end else if (hit_count == COUNT_W'(1)) begin
      result_next.status             = ST_UNIQUE;
      result_next.completed_word     = first_word;
      result_next.prefix_match_count = hit_count;
    end else begin
      result_next.status             = ST_NONE;
      result_next.completed_word     = q_word;
      result_next.prefix_match_count = hit_count;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      words_in_use <= USE_RESET;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      if (cfg_valid && cfg_ready) words_in_use <= cfg_data;
      if (finish_fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Scan counter, query context and accumulators
  always_ff @(posedge clk) begin
    if (query_fire) begin
      q_word      <= request.query_word;
      q_len       <= request.query_length;
      q_long      <= too_long;
      pmask       <= low_bytes_mask(request.query_length);
      scan_idx    <= '0;
      scan_n      <= n_lim;
      hit_count   <= '0;
      exact_found <= 1'b0;
    end else begin
      if (rd_en) scan_idx <= scan_idx + COUNT_W'(1);
      if (rd_valid && hit) begin
        hit_count <= hit_count + COUNT_W'(1);
        if (hit_count == '0) first_word <= rd_data;
        if (ends && !exact_found) begin
          exact_found <= 1'b1;
          exact_word  <= rd_data;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (finish_fire) result <= result_next;
  end

endmodule

`default_nettype wire

// ----- rtl/dpa_checker.sv -----
`default_nettype none

module dpa_checker
  import dpa_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // A stalled result item stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result item changed while stalled");

  // Too long queries report no prefix matches
  a_long_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_TOO_LONG |-> result.prefix_match_count == '0)
    else $error("too long query reports prefix matches");

  // An exact match is also a prefix match
  a_exact_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_EXACT |-> result.prefix_match_count != '0)
    else $error("exact match with zero prefix count");

  // A unique completion means exactly one prefix match
  a_unique_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_UNIQUE |->
      result.prefix_match_count == COUNT_W'(1))
    else $error("unique completion with prefix count other than one");

endmodule

bind dictionary_prefix_autocomplete dpa_checker u_dpa_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
